// ----- rtl/tbbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbp_pkg: shared types and constants of the two-bit branch predictor
// Entry layout, stream payload widths and the entry update function.
// ----------------------------------------------------------------------------
package tbbp_pkg;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 32;

	// Stream payloads, padded to whole bytes
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 72;

	// One table entry: last outcome in bit 1, prediction in bit 0
	typedef struct packed {
		logic last;
		logic pred;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{last: 1'b0, pred: 1'b0};

	// Hysteresis update: the prediction only flips after two agreeing outcomes
	function automatic entry_t next_entry(input entry_t cur, input logic taken);
		entry_t nxt;
		nxt = cur;
		if (cur.last == cur.pred) begin
			nxt.last = taken;
		end else if (taken == cur.last) begin
			nxt.pred = taken;
		end else begin
			nxt.last = taken;
		end
		return nxt;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + COUNT_W'(1);
	endfunction

endpackage

// ----- rtl/tbbp_index.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbp_index: table index pipeline
// Registers the request and reduces (address >> 1) mod ENTRIES by a
// reciprocal multiply, a back multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module tbbp_index #(
	parameter int ENTRIES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [tbbp_pkg::ADDR_W-1:0]       in_addr,
	input  logic                              in_taken,
	output logic                              out_valid,
	output logic [$clog2(ENTRIES)-1:0]        out_idx,
	output logic                              out_taken
);
	import tbbp_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int X_W   = ADDR_W - 1;
	// floor(2^32 / ENTRIES): the estimate is the quotient or one below it
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(ENTRIES));
	localparam logic [X_W-1:0] ENT_X = X_W'(ENTRIES);

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic [X_W-1:0]   x_s1, x_s2, x_s3;
	logic             taken_s1, taken_s2, taken_s3, taken_s4;
	logic [X_W-1:0]   q_s2;
	logic [X_W-1:0]   qn_s3;
	logic [IDX_W-1:0] idx_s4;

	logic [X_W+31:0]  prod1;
	logic [X_W-1:0]   diff;
	logic [X_W-1:0]   rem;

	assign prod1 = {32'b0, x_s1} * {{X_W{1'b0}}, RECIP};
	assign diff  = x_s3 - qn_s3;
	assign rem   = (diff >= ENT_X) ? diff - ENT_X : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= in_addr[ADDR_W-1:1];
			taken_s1 <= in_taken;
			x_s2     <= x_s1;
			q_s2     <= prod1[X_W+31:32];
			taken_s2 <= taken_s1;
			x_s3     <= x_s2;
			qn_s3    <= X_W'(q_s2 * ENT_X);
			taken_s3 <= taken_s2;
			idx_s4   <= rem[IDX_W-1:0];
			taken_s4 <= taken_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_idx   = idx_s4;
	assign out_taken = taken_s4;

endmodule

// ----- rtl/tbbp_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbp_table: predictor entry memory
// One write and one registered read port, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module tbbp_table #(
	parameter int ENTRIES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_idx,
	output tbbp_pkg::entry_t           rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_idx,
	input  tbbp_pkg::entry_t           wr_data,
	output logic                       busy
);
	import tbbp_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	entry_t           mem [ENTRIES];
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	entry_t           mem_wd;

	// sweep every entry to zero, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == IDX_W'(ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + IDX_W'(1);
		end
	end

	assign mem_we = clr_busy_q || wr_en;
	assign mem_wa = clr_busy_q ? clr_idx_q : wr_idx;
	assign mem_wd = clr_busy_q ? ENTRY_RESET : wr_data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

	assign busy = clr_busy_q;

endmodule

// ----- rtl/two_bit_branch_predictor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_bit_branch_predictor: two-bit hysteresis branch predictor
// Takes resolved branches, returns the prediction, a hit flag and counts.
// ----------------------------------------------------------------------------
// Each request carries a resolved conditional branch (address and outcome).
// The block picks an untagged entry at (address >> 1) mod ENTRIES, reports
// that entry's prediction bit, whether it matched the outcome, and saturating
// 32-bit counts of hits and branches (this branch included), then updates the
// entry. It takes one request per cycle unless stalled; a request passes
// through the index pipeline (reciprocal multiply, back multiply, subtract),
// the registered table read and the result register. Back-pressure on the
// result side stalls the whole pipeline. After reset the table is swept to
// zero, one entry per cycle, and no request is taken until the sweep is
// done. Aliasing branches share an entry.
// ----------------------------------------------------------------------------
module two_bit_branch_predictor #(
	parameter int ENTRIES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [31:0] branch_address, [32] taken, [39:33] zero
	input  logic [tbbp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [0] predicted_taken, [1] correct, [33:2] correct_count,
	// [65:34] branch_count, [71:66] zero
	output logic [tbbp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tbbp_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	// pipeline advance: the result register is empty or being drained
	logic             en;
	logic             busy;

	logic             valid_s4;
	logic [IDX_W-1:0] idx_s4;
	logic             taken_s4;

	logic             valid_s5;
	logic [IDX_W-1:0] idx_s5;
	logic             taken_s5;
	logic             fwd_s5;
	entry_t           fwd_data_s5;
	entry_t           rd_data;

	entry_t           cur_entry;
	entry_t           new_entry;
	logic             hit;
	logic [COUNT_W-1:0] hit_q, seen_q;
	logic [COUNT_W-1:0] hit_nxt, seen_nxt;

	logic             out_valid_q;
	logic             out_pred_q;
	logic             out_hit_q;
	logic [COUNT_W-1:0] out_hit_cnt_q;
	logic [COUNT_W-1:0] out_seen_cnt_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en && !busy;

	// index pipeline: request register through reduced table index
	tbbp_index #(
		.ENTRIES (ENTRIES)
	) u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid && s_axis_tready),
		.in_addr   (s_axis_tdata[ADDR_W-1:0]),
		.in_taken  (s_axis_tdata[ADDR_W]),
		.out_valid (valid_s4),
		.out_idx   (idx_s4),
		.out_taken (taken_s4)
	);

	// entry memory: read in stage 4, write back in stage 5
	tbbp_table #(
		.ENTRIES (ENTRIES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (en),
		.rd_idx  (idx_s4),
		.rd_data (rd_data),
		.wr_en   (en && valid_s5),
		.wr_idx  (idx_s5),
		.wr_data (new_entry),
		.busy    (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	// The read in stage 4 sees the memory before the stage 5 write lands,
	// so bypass the fresh entry when both stages hit the same index.
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s5      <= idx_s4;
			taken_s5    <= taken_s4;
			fwd_s5      <= valid_s5 && (idx_s5 == idx_s4);
			fwd_data_s5 <= new_entry;
		end
	end

	assign cur_entry = fwd_s5 ? fwd_data_s5 : rd_data;
	assign new_entry = next_entry(cur_entry, taken_s5);
	assign hit       = (cur_entry.pred == taken_s5);
	assign hit_nxt   = hit ? sat_inc(hit_q) : hit_q;
	assign seen_nxt  = sat_inc(seen_q);

	// running counts and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s5;
			if (valid_s5) begin
				hit_q  <= hit_nxt;
				seen_q <= seen_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s5) begin
			out_pred_q     <= cur_entry.pred;
			out_hit_q      <= hit;
			out_hit_cnt_q  <= hit_nxt;
			out_seen_cnt_q <= seen_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_seen_cnt_q, out_hit_cnt_q, out_hit_q, out_pred_q};

	// no request enters while the table is being swept
	assert property (@(posedge clk) disable iff (!arst_n) busy |-> !s_axis_tready)
		else $error("request taken during table clear");

	// no write-back may collide with the clearing sweep
	assert property (@(posedge clk) disable iff (!arst_n) busy |-> !valid_s5)
		else $error("entry update during table clear");

	// hits never outnumber branches
	assert property (@(posedge clk) disable iff (!arst_n) hit_q <= seen_q)
		else $error("hit count above branch count");

	// branch count moves only by one per retired branch
	assert property (@(posedge clk) disable iff (!arst_n)
		!(en && valid_s5) |=> $stable(seen_q))
		else $error("branch count changed without a branch");

endmodule
